### hw/rtl/nstp_pkg.sv
// Shared types and codes of the nested section timing profiler.
`default_nettype none
package nstp_pkg;

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_END   = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] ST_BEGUN   = 3'd0;
    localparam logic [2:0] ST_ENDED   = 3'd1;
    localparam logic [2:0] ST_CLEARED = 3'd2;
    localparam logic [2:0] ST_BAD     = 3'd3;
    localparam logic [2:0] ST_EMPTY   = 3'd4;
    localparam logic [2:0] ST_FULL    = 3'd5;

    localparam logic [6:0]  WINDOW_MASK = 7'd127;
    localparam logic [31:0] MIN_INIT    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  group;
        logic [5:0]  slot;
        logic [31:0] timestamp;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  ended_slot;
        logic [31:0] duration;
        logic [31:0] count_total;
        logic [63:0] time_total;
        logic [31:0] window_max;
        logic [31:0] window_min;
        logic [63:0] window_sum;
        logic        window_closed;
    } t_out_item;

    // One open section on a group's stack.
    typedef struct packed {
        logic [5:0]  slot;
        logic [31:0] start;
    } t_open_entry;

    // All statistics of one slot.
    typedef struct packed {
        logic [31:0] count;
        logic [63:0] total;
        logic [31:0] run_max;
        logic [31:0] run_min;
        logic [63:0] run_sum;
        logic [31:0] lat_max;
        logic [31:0] lat_min;
        logic [63:0] lat_sum;
    } t_stat_entry;

    localparam t_stat_entry STAT_INIT = '{
        count: 32'd0, total: 64'd0, run_max: 32'd0, run_min: MIN_INIT,
        run_sum: 64'd0, lat_max: 32'd0, lat_min: 32'd0, lat_sum: 64'd0};

    // Write request into the statistics memory.
    typedef struct packed {
        logic        we;
        logic        clear;
        t_stat_entry data;
    } t_stat_wr;

endpackage
`default_nettype wire

### hw/rtl/nstp_stack.sv
// Section stack memory of all groups, one write and one registered read port.
`default_nettype none
module nstp_stack
    import nstp_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_open_entry   i_wr_data,
    input  wire logic [AW-1:0] i_rd_addr,
    output t_open_entry        o_rd_data
);

    t_open_entry mem [DEPTH];
    t_open_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

### hw/rtl/nstp_stats.sv
// Per-slot statistics memory with valid bits standing in for the reset value.
`default_nettype none
module nstp_stats
    import nstp_pkg::*;
#(
    parameter int SLOTS = 64,
    parameter int SW    = 6
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [SW-1:0] i_addr,
    input  wire t_stat_wr      i_wr,
    output t_stat_entry        o_rd_data
);

    t_stat_entry mem [SLOTS];
    logic        r_vld [SLOTS];
    t_stat_entry r_rd_data;
    logic        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            mem[i_addr] <= i_wr.data;
        end
        r_rd_data <= mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_wr.clear) begin
            for (int k = 0; k < SLOTS; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr.we) begin
                r_vld[i_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_addr];
        end
    end

    // Unwritten entries read as the cleared value.
    assign o_rd_data = r_rd_vld ? r_rd_data : STAT_INIT;

endmodule
`default_nettype wire

### hw/rtl/nested_section_timing_profiler.sv
// Nested section timing profiler: top level with event sequencer and result register.
// Begin, clear and rejected items go straight to the output step; an end item first
// reads the stack, then read-modify-writes the statistics. A new item is taken only
// once the last is through, and the output step waits while the result is not taken.
// Reset: stack levels, group count and statistics valid bits clear at once, so
// no sweep is needed; the stack memory stays undefined until pushed.
`default_nettype none
module nested_section_timing_profiler
    import nstp_pkg::*;
#(
    parameter int SLOTS       = 64,
    parameter int GROUPS      = 4,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [2:0] i_cfg_data,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire t_in_item   i_item,
    output logic            o_valid,
    input  wire logic       i_ready,
    output t_out_item       o_item
);

    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int LW    = $clog2(STACK_DEPTH + 1);
    localparam int SDEP  = GROUPS * STACK_DEPTH;
    localparam int PW    = (SDEP > 1) ? $clog2(SDEP) : 1;

    typedef enum logic [1:0] {S_IDLE, S_POP, S_UPD, S_OUT} t_state;

    t_state         r_state;
    logic [2:0]     r_groups;
    logic [LW-1:0]  r_lvl [GROUPS];
    logic [31:0]    r_ts;
    logic [5:0]     r_eslot;
    logic [31:0]    r_dur;
    t_out_item      r_res;
    t_out_item      r_out;
    logic           r_out_valid;

    // Decode of the incoming item.
    logic [4:0]     grp_ext;
    logic [GW-1:0]  gidx;
    logic [LW-1:0]  lvl;
    logic           grp_bad;
    logic           slot_bad;
    logic [PW-1:0]  push_pos;
    logic [PW-1:0]  pop_pos;
    logic           accept;
    logic           stk_we;
    t_open_entry    stk_wdata;
    t_open_entry    stk_rdata;
    logic [PW-1:0]  stk_raddr;
    t_out_item      n_res;
    logic           do_pop;

    // Pop and statistics path.
    logic [5:0]     pop_slot;
    logic [31:0]    pop_dur;
    logic [8:0]     slot_ext;
    logic [SW-1:0]  stat_addr;
    t_stat_entry    st_rd;
    t_stat_entry    st_new;
    t_stat_wr       st_wr;
    logic [31:0]    cnt_inc;
    logic           closed;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign accept      = i_valid && o_ready;
    assign o_valid     = r_out_valid;
    assign o_item      = r_out;

    assign grp_ext  = {3'b000, i_item.group};
    assign gidx     = grp_ext[GW-1:0];
    assign lvl      = r_lvl[gidx];
    assign grp_bad  = ({1'b0, i_item.group} >= r_groups) || (grp_ext >= 5'(GROUPS));
    assign slot_bad = ({3'b000, i_item.slot} >= 9'(SLOTS));
    assign push_pos = PW'(32'(gidx) * STACK_DEPTH + 32'(lvl));
    assign pop_pos  = PW'(32'(gidx) * STACK_DEPTH + 32'(lvl) - 32'd1);

    // Push on an accepted, valid begin item.
    assign stk_we = accept && (i_item.action == ACT_BEGIN) && !grp_bad && !slot_bad
                    && (32'(lvl) < STACK_DEPTH);
    assign stk_wdata = '{slot: i_item.slot, start: i_item.timestamp};
    assign stk_raddr = pop_pos;

    // Status of a begin, clear or rejected item; an end item that pops fills
    // its result later in the update step.
    always_comb begin
        n_res  = '0;
        do_pop = 1'b0;
        if (i_item.action == ACT_CLEAR) begin
            n_res.status = ST_CLEARED;
        end else if (i_item.action != ACT_BEGIN && i_item.action != ACT_END) begin
            n_res.status = ST_BAD;
        end else if (grp_bad) begin
            n_res.status = ST_BAD;
        end else if (i_item.action == ACT_BEGIN) begin
            if (slot_bad) begin
                n_res.status = ST_BAD;
            end else if (32'(lvl) >= STACK_DEPTH) begin
                n_res.status = ST_FULL;
            end else begin
                n_res.status = ST_BEGUN;
            end
        end else if (lvl == '0) begin
            n_res.status = ST_EMPTY;
        end else begin
            do_pop = accept;
        end
    end

    nstp_stack #(.DEPTH(SDEP), .AW(PW)) u_stack (
        .i_clk     (i_clk),
        .i_we      (stk_we),
        .i_wr_addr (push_pos),
        .i_wr_data (stk_wdata),
        .i_rd_addr (stk_raddr),
        .o_rd_data (stk_rdata)
    );

    // Popped section: clamp the slot, take the wrapping duration.
    assign pop_slot = ({3'b000, stk_rdata.slot} >= 9'(SLOTS)) ? 6'd0 : stk_rdata.slot;
    assign pop_dur  = r_ts - stk_rdata.start;
    assign slot_ext = (r_state == S_POP) ? {3'b000, pop_slot} : {3'b000, r_eslot};
    assign stat_addr = slot_ext[SW-1:0];

    // Fold the duration into the slot's figures; close the window every 128.
    always_comb begin
        cnt_inc        = st_rd.count + 32'd1;
        closed         = ((cnt_inc[6:0] & WINDOW_MASK) == 7'd0);
        st_new         = st_rd;
        st_new.count   = cnt_inc;
        st_new.total   = st_rd.total + {32'd0, r_dur};
        st_new.run_max = (st_rd.run_max < r_dur) ? r_dur : st_rd.run_max;
        st_new.run_min = (st_rd.run_min > r_dur) ? r_dur : st_rd.run_min;
        st_new.run_sum = st_rd.run_sum + {32'd0, r_dur};
        if (closed) begin
            st_new.lat_max = st_new.run_max;
            st_new.lat_min = st_new.run_min;
            st_new.lat_sum = st_new.run_sum;
            st_new.run_max = 32'd0;
            st_new.run_min = MIN_INIT;
            st_new.run_sum = 64'd0;
        end
    end

    assign st_wr.we    = (r_state == S_UPD);
    assign st_wr.clear = accept && (i_item.action == ACT_CLEAR);
    assign st_wr.data  = st_new;

    nstp_stats #(.SLOTS(SLOTS), .SW(SW)) u_stats (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_addr    (stat_addr),
        .i_wr      (st_wr),
        .o_rd_data (st_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_groups    <= 3'd0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < GROUPS; k++) begin
                r_lvl[k] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_groups <= i_cfg_data;
            end
            // Drop the result once taken, unless a new one replaces it.
            if (r_out_valid && i_ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res <= n_res;
                        r_ts  <= i_item.timestamp;
                        if (stk_we) begin
                            r_lvl[gidx] <= lvl + LW'(1);
                        end else if (do_pop) begin
                            // Pop: stack read issued this cycle.
                            r_lvl[gidx] <= lvl - LW'(1);
                        end
                        r_state <= do_pop ? S_POP : S_OUT;
                    end
                end
                S_POP: begin
                    r_eslot <= pop_slot;
                    r_dur   <= pop_dur;
                    r_state <= S_UPD;
                end
                S_UPD: begin
                    r_res.status        <= ST_ENDED;
                    r_res.ended_slot    <= r_eslot;
                    r_res.duration      <= r_dur;
                    r_res.count_total   <= st_new.count;
                    r_res.time_total    <= st_new.total;
                    r_res.window_max    <= st_new.lat_max;
                    r_res.window_min    <= st_new.lat_min;
                    r_res.window_sum    <= st_new.lat_sum;
                    r_res.window_closed <= closed;
                    r_state             <= S_OUT;
                end
                S_OUT: begin
                    // Hold until the result register is free.
                    if (!r_out_valid || i_ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // A push never lands on a full stack.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_we |-> (32'(lvl) < STACK_DEPTH))
        else $error("push onto full stack");

    // The statistics update always yields an ended result.
    a_upd_ended: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD) |=> (r_res.status == ST_ENDED))
        else $error("update did not end a section");

    // A result is dropped only when taken.
    a_out_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_ready) |=> r_out_valid)
        else $error("result lost");

    // After the pop step the update step follows, during which no item is taken.
    a_seq_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_POP) |=> (r_state == S_UPD) && !o_ready)
        else $error("pop sequence broken");

endmodule
`default_nettype wire
